>>> src/stt_pkg.sv
package stt_pkg;

    localparam int DEF_TIMER_SLOTS = 16;
    localparam int MAX_RESULTS     = 16;

    localparam int OP_W     = 2;
    localparam int OWNER_W  = 16;
    localparam int PERIOD_W = 32;
    localparam int DELTA_W  = 32;
    localparam int ID_W     = 32;
    localparam int KIND_W   = 2;
    localparam int TIME_W   = 48;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_TICK    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_IDLE  = 2'd3
    } t_kind;

    // one stored timer
    typedef struct packed {
        logic [OWNER_W-1:0]  owner;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   start;
        logic [PERIOD_W-1:0] period;
        logic                rep;
    } t_entry;

endpackage

>>> src/stt_ifs.sv
interface stt_in_if;
    import stt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [OWNER_W-1:0]  owner;
    logic [PERIOD_W-1:0] interval;
    logic                repeat_req;
    logic [DELTA_W-1:0]  tick_delta;

    modport source (output valid, op, owner, interval, repeat_req, tick_delta, input ready);
    modport sink   (input valid, op, owner, interval, repeat_req, tick_delta, output ready);
endinterface

interface stt_out_if;
    import stt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    timer_id;
    logic [OWNER_W-1:0] owner_out;
    logic               last;

    modport source (output valid, kind, timer_id, owner_out, last, input ready);
    modport sink   (input valid, kind, timer_id, owner_out, last, output ready);
endinterface

>>> src/software_timer_table_top.sv
// timer table: holds up to TIMER_SLOTS timers in insertion order
//
// input channel (i_in): one beat per command. add stores a timer starting
// at the current time and answers with its id (or full), tick advances time
// and reports the timers it crosses (at most MAX_RESULTS), release drops
// all timers of an owner with no answer. op 3 is dropped silently.
// output channel (o_out): result beats; last marks the final beat of a
// command. a tick that fires nothing answers with one idle beat.
//
// add answers through the output register and holds the block until its
// beat is loaded. tick and release walk the table one slot at a time, each
// through memory read, deadline add, compare and write back, and hold the
// block until the walk ends. ready is high only while the sequencer is idle.
// reset clears time, id counter and entry count; the table contents are
// not cleared since only entries below the count are ever read.
// when the receiver stalls, the output register holds its beat and the
// walk pauses at the next firing that needs to leave the block.
module software_timer_table_top #(
    parameter int TIMER_SLOTS = stt_pkg::DEF_TIMER_SLOTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stt_in_if.sink        i_in,
    stt_out_if.source     o_out
);
    import stt_pkg::*;

    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int RW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_RD,
        S_CALC,
        S_ACT,
        S_FIN
    } t_state;

    t_state r_state;

    // architectural state
    logic [TIME_W-1:0] r_now;
    logic [ID_W-1:0]   r_next_id;
    logic [CW-1:0]     r_count;

    // latched command
    logic [OP_W-1:0]     r_op;
    logic [OWNER_W-1:0]  r_owner;
    logic [PERIOD_W-1:0] r_interval;
    logic                r_rep;

    // walk state
    logic [TIME_W-1:0] r_old;
    logic [TIME_W-1:0] r_new;
    logic [CW-1:0]     r_scan;
    logic [CW-1:0]     r_keep;
    logic [RW-1:0]     r_nres;

    // firing held back until we know whether it is the last one
    logic               r_pend_v;
    logic [ID_W-1:0]    r_pend_id;
    logic [OWNER_W-1:0] r_pend_own;

    // output register
    logic               r_ov;
    logic [KIND_W-1:0]  r_okind;
    logic [ID_W-1:0]    r_oid;
    logic [OWNER_W-1:0] r_oown;
    logic               r_olast;

    logic [TIME_W:0]   n_sum;
    logic [TIME_W-1:0] n_sat;
    logic              can_load;
    logic              out_load;
    logic              fire;
    logic              is_tick;
    logic              drop;
    logic              report;
    logic              stall;
    logic              last_slot;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic              mem_re;
    t_entry            rd;

    stt_mem #(
        .DEPTH (TIMER_SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_scan[IW-1:0]),
        .o_rdata (rd)
    );

    stt_fire_unit u_fire (
        .i_clk    (i_clk),
        .i_load   (r_state == S_CALC),
        .i_start  (rd.start),
        .i_period (rd.period),
        .i_old    (r_old),
        .i_new    (r_new),
        .o_fire   (fire)
    );

    // saturating time advance
    assign n_sum = {1'b0, r_now} + {{(TIME_W + 1 - DELTA_W){1'b0}}, i_in.tick_delta};
    assign n_sat = n_sum[TIME_W] ? {TIME_W{1'b1}} : n_sum[TIME_W-1:0];

    assign can_load  = !r_ov || o_out.ready;
    assign is_tick   = (r_op == OP_TICK);
    assign report    = fire && (r_nres < RW'(MAX_RESULTS));
    // a tick removes fired one-shots, a release removes the owner's timers
    assign drop      = is_tick ? (fire && !rd.rep) : (rd.owner == r_owner);
    // a second reported firing pushes the held one out
    assign stall     = is_tick && report && r_pend_v && !can_load;
    assign last_slot = (CW'(r_scan + 1'b1) == r_count);

    // a new beat enters the output register this cycle
    assign out_load = ((r_state == S_ADD) && can_load)
                   || ((r_state == S_ACT) && is_tick && report && r_pend_v && can_load)
                   || ((r_state == S_FIN) && is_tick && can_load);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_keep[IW-1:0];
        mem_wdata = rd;
        mem_re    = (r_state == S_RD);
        if (r_state == S_ADD) begin
            mem_waddr        = r_count[IW-1:0];
            mem_wdata.owner  = r_owner;
            mem_wdata.id     = r_next_id + 1'b1;
            mem_wdata.start  = r_now;
            mem_wdata.period = r_interval;
            mem_wdata.rep    = r_rep;
            mem_we           = can_load && (r_count != CW'(TIMER_SLOTS));
        end else if (r_state == S_ACT) begin
            if (is_tick && fire) begin
                mem_wdata.start = r_new;
            end
            mem_we = !stall && !drop;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid     = r_ov;
    assign o_out.kind      = r_okind;
    assign o_out.timer_id  = r_oid;
    assign o_out.owner_out = r_oown;
    assign o_out.last      = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_now     <= '0;
            r_next_id <= '0;
            r_count   <= '0;
            r_ov      <= 1'b0;
            r_pend_v  <= 1'b0;
            r_scan    <= '0;
            r_keep    <= '0;
            r_nres    <= '0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op       <= i_in.op;
                        r_owner    <= i_in.owner;
                        r_interval <= i_in.interval;
                        r_rep      <= i_in.repeat_req;
                        r_scan     <= '0;
                        r_keep     <= '0;
                        r_nres     <= '0;
                        r_pend_v   <= 1'b0;
                        case (i_in.op)
                            OP_ADD: begin
                                r_state <= S_ADD;
                            end
                            OP_TICK: begin
                                r_old   <= r_now;
                                r_new   <= n_sat;
                                r_now   <= n_sat;
                                r_state <= (r_count == '0) ? S_FIN : S_RD;
                            end
                            OP_RELEASE: begin
                                r_state <= (r_count == '0) ? S_FIN : S_RD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    if (can_load) begin
                        r_olast <= 1'b1;
                        r_oown  <= '0;
                        if (r_count == CW'(TIMER_SLOTS)) begin
                            r_okind <= KIND_FULL;
                            r_oid   <= '0;
                        end else begin
                            r_okind   <= KIND_ADDED;
                            r_oid     <= r_next_id + 1'b1;
                            r_next_id <= r_next_id + 1'b1;
                            r_count   <= CW'(r_count + 1'b1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    if (!stall) begin
                        if (is_tick && report) begin
                            if (r_pend_v) begin
                                r_okind <= KIND_FIRED;
                                r_oid   <= r_pend_id;
                                r_oown  <= r_pend_own;
                                r_olast <= 1'b0;
                            end
                            r_pend_v   <= 1'b1;
                            r_pend_id  <= rd.id;
                            r_pend_own <= rd.owner;
                            r_nres     <= RW'(r_nres + 1'b1);
                        end
                        if (!drop) begin
                            r_keep <= CW'(r_keep + 1'b1);
                        end
                        r_scan  <= CW'(r_scan + 1'b1);
                        r_state <= last_slot ? S_FIN : S_RD;
                    end
                end
                S_FIN: begin
                    if (!is_tick) begin
                        r_count <= r_keep;
                        r_state <= S_IDLE;
                    end else if (can_load) begin
                        r_olast <= 1'b1;
                        if (r_pend_v) begin
                            r_okind <= KIND_FIRED;
                            r_oid   <= r_pend_id;
                            r_oown  <= r_pend_own;
                        end else begin
                            r_okind <= KIND_IDLE;
                            r_oid   <= '0;
                            r_oown  <= '0;
                        end
                        r_pend_v <= 1'b0;
                        r_count  <= r_keep;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> src/stt_mem.sv
module stt_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IW-1:0]    i_waddr,
    input  stt_pkg::t_entry  i_wdata,
    input  logic             i_re,
    input  logic [IW-1:0]    i_raddr,
    output stt_pkg::t_entry  o_rdata
);
    import stt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/stt_fire_unit.sv
module stt_fire_unit (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [stt_pkg::TIME_W-1:0]    i_start,
    input  logic [stt_pkg::PERIOD_W-1:0]  i_period,
    input  logic [stt_pkg::TIME_W-1:0]    i_old,
    input  logic [stt_pkg::TIME_W-1:0]    i_new,
    output logic                          o_fire
);
    import stt_pkg::*;

    // deadline kept one bit wider so it never wraps
    logic [TIME_W:0] r_deadline;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_deadline <= {1'b0, i_start} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, i_period};
        end
    end

    assign o_fire = ({1'b0, i_old} <= r_deadline) && ({1'b0, i_new} > r_deadline);
endmodule
